/* rtl/core/nbls_pkg.sv */
// Shared types, codes and helpers for the leapfrog N-body step engine.
// No dependencies; used by nbody_leapfrog_step.
`timescale 1ns / 1ps

package nbls_pkg;

   // action codes on req_tuser
   localparam logic [1:0] ACT_LOAD = 2'd0;
   localparam logic [1:0] ACT_STEP = 2'd1;
   localparam logic [1:0] ACT_READ = 2'd2;

   // result kinds on rsp_tuser
   localparam logic KIND_BODY = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   // register indexes on csr_addr
   localparam logic [1:0] CSR_SOFTENING = 2'd0;
   localparam logic [1:0] CSR_TIME_STEP = 2'd1;
   localparam logic [1:0] CSR_ACTIVE    = 2'd2;

   localparam logic [30:0] SOFTENING_RESET = 31'd8493;
   localparam logic [30:0] TIME_STEP_RESET = 31'd512;
   localparam logic [9:0]  ACTIVE_RESET    = 10'd512;

   localparam logic [49:0] R_CAP_WIDE = 50'h0_FFFF_FFFF_FFFF;
   localparam logic [47:0] R_CAP      = 48'hFFFF_FFFF_FFFF;
   localparam logic [62:0] F_CAP_WIDE = 63'h7FFF_FFFF;
   localparam logic [30:0] F_CAP      = 31'h7FFF_FFFF;

   localparam logic [5:0] DIV1_STEPS = 6'd47;
   localparam logic [5:0] SQRT_STEPS = 6'd32;
   localparam logic [5:0] DIV2_STEPS = 6'd63;

   typedef enum logic [19:0] {
      ST_CLEAR  = 20'b0000_0000_0000_0000_0001,
      ST_IDLE   = 20'b0000_0000_0000_0000_0010,
      ST_READ   = 20'b0000_0000_0000_0000_0100,
      ST_DONE   = 20'b0000_0000_0000_0000_1000,
      ST_P_RD   = 20'b0000_0000_0000_0001_0000,
      ST_P_LD   = 20'b0000_0000_0000_0010_0000,
      ST_P_MUL  = 20'b0000_0000_0000_0100_0000,
      ST_P_ADD  = 20'b0000_0000_0000_1000_0000,
      ST_P_WR   = 20'b0000_0000_0001_0000_0000,
      ST_G_RDI  = 20'b0000_0000_0010_0000_0000,
      ST_G_LDI  = 20'b0000_0000_0100_0000_0000,
      ST_G_RDJ  = 20'b0000_0000_1000_0000_0000,
      ST_G_LDJ  = 20'b0000_0001_0000_0000_0000,
      ST_G_SQM  = 20'b0000_0010_0000_0000_0000,
      ST_G_SQA  = 20'b0000_0100_0000_0000_0000,
      ST_G_CAP  = 20'b0000_1000_0000_0000_0000,
      ST_G_DIV1 = 20'b0001_0000_0000_0000_0000,
      ST_G_DIV2 = 20'b0010_0000_0000_0000_0000,
      ST_G_FM   = 20'b0100_0000_0000_0000_0000,
      ST_G_FA   = 20'b1000_0000_0000_0000_0000
   } state_type;

   typedef enum logic [3:0] {
      PH_KICK1 = 4'b0001,
      PH_DRIFT = 4'b0010,
      PH_GRAV  = 4'b0100,
      PH_KICK2 = 4'b1000
   } phase_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh0000_0000_7FFF_FFFF)
         r = 32'sh7FFF_FFFF;
      else if (v < -64'sh0000_0000_8000_0000)
         r = 32'sh8000_0000;
      else
         r = v[31:0];
      return r;
   endfunction

endpackage

/* rtl/core/nbls_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module nbls_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we)
         mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/nbody_leapfrog_step.sv */
// Kick-drift-kick leapfrog N-body engine, body state held in block RAMs.
// Depends on nbls_pkg and nbls_ram.
`timescale 1ns / 1ps
//
//  channel | direction | handshake            | payload
//  req     | in        | req_tvalid/tready    | tuser: action; tdata: body
//  rsp     | out       | rsp_tvalid/tready    | tuser: result_kind; tdata: body
//  csr     | in        | csr_we               | csr_addr, csr_wdata
//
// Load: written to the RAMs as it is accepted. Read: the RAM data is registered,
// then taken into the output register once that is free. Step: one item at a
// time, a kick or drift pass over each body, plus per body pair the shared
// 47-step divider, 63-step divider and 32-step root. After reset every
// acceleration RAM entry is cleared before req_tready rises. A finished result
// sits in the output register while the next item is taken.

module nbody_leapfrog_step #(
   parameter int MAX_BODIES = 512
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,   // action
   // body_index, in_pos_x, in_pos_y, in_pos_z, in_vel_x, in_vel_y, in_vel_z, in_mass
   input  logic [231:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic         rsp_tuser,   // result_kind
   // out_index, out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y, out_vel_z, pad
   output logic [207:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [30:0]  csr_wdata
);

   localparam int AW = $clog2(MAX_BODIES);
   localparam int CW = AW + 1;

   // request fields
   logic [8:0]   req_index;
   logic [95:0]  req_pos;
   logic [95:0]  req_vel;
   logic [30:0]  req_mass;
   logic         req_fire;
   logic         req_in_range;

   assign req_index    = req_tdata[8:0];
   assign req_pos      = req_tdata[104:9];
   assign req_vel      = req_tdata[200:105];
   assign req_mass     = req_tdata[231:201];
   assign req_fire     = req_tvalid && req_tready;
   assign req_in_range = 32'(req_index) < MAX_BODIES;

   nbls_pkg::state_type state_ff, state_in;
   nbls_pkg::phase_type phase_ff, phase_in;

   logic [30:0] soft_ff, dt_ff;
   logic [9:0]  act_ff;
   logic [CW-1:0] n_ff, n_in, i_ff, i_in, j_ff, j_in, clr_ff, clr_in;
   logic [8:0]  idx_ff, idx_in;
   logic        oob_ff, oob_in;
   logic [1:0]  ax_ff, ax_in;

   logic signed [31:0] base_ff [3];
   logic signed [31:0] base_in [3];
   logic signed [31:0] opa_ff [3];
   logic signed [31:0] opa_in [3];
   logic [30:0]        mulb_ff, mulb_in;
   logic [63:0]        prod_ff;
   logic signed [31:0] pi_ff [3];
   logic signed [31:0] pi_in [3];
   logic [31:0]        dmag_ff [3];
   logic [31:0]        dmag_in [3];
   logic [2:0]         dneg_ff, dneg_in;
   logic [30:0]        mass_ff, mass_in;
   logic [49:0]        racc_ff, racc_in;
   logic [47:0]        r2_ff, r2_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [46:0]        num1_ff, num1_in;
   logic [47:0]        rem1_ff, rem1_in;
   logic [63:0]        sqsrc_ff, sqsrc_in;
   logic [33:0]        sqrem_ff, sqrem_in;
   logic [31:0]        root_ff, root_in;
   logic [62:0]        num2_ff, num2_in;
   logic [31:0]        rem2_ff, rem2_in;
   logic [30:0]        f_ff, f_in;
   logic signed [63:0] sum_ff [3];
   logic signed [63:0] sum_in [3];

   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_kind_ff, rsp_kind_in;
   logic [207:0] rsp_data_ff, rsp_data_in;
   logic         slot_free;

   // RAM ports
   logic          pos_we, vel_we, acc_we, mass_we;
   logic [AW-1:0] pos_waddr, vel_waddr, acc_waddr, mass_waddr;
   logic [AW-1:0] pos_raddr, vel_raddr, acc_raddr, mass_raddr;
   logic [95:0]   pos_wdata, vel_wdata, acc_wdata;
   logic [95:0]   pos_rdata, vel_rdata, acc_rdata;
   logic [30:0]   mass_rdata;

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   logic [31:0] opa_mag;
   logic        opa_neg;

   // datapath helpers
   logic [47:0]        prod_hi;
   logic signed [63:0] p_term, p_sum;
   logic signed [32:0] d_diff [3];
   logic [35:0]        sq_tmp, sq_trial, sq_diff;
   logic [48:0]        d1_tmp, d1_div, d1_diff;
   logic               d1_ge;
   logic [32:0]        d2_tmp, d2_div, d2_diff;
   logic               d2_ge;
   logic [47:0]        r2_cap;

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == nbls_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign opa_neg = opa_ff[ax_ff][31];
   assign opa_mag = opa_neg ? 32'(-opa_ff[ax_ff]) : 32'(opa_ff[ax_ff]);
   assign prod_hi = prod_ff[63:16];

   always_comb begin
      mul_a = dmag_ff[ax_ff];
      mul_b = {1'b0, f_ff};
      if (state_ff == nbls_pkg::ST_P_MUL) begin
         mul_a = opa_mag;
         mul_b = {1'b0, mulb_ff};
      end else if (state_ff == nbls_pkg::ST_G_SQM) begin
         mul_b = dmag_ff[ax_ff];
      end
   end

   // kick/drift add: base + mul_q(opa, mulb)
   assign p_term = opa_neg ? -$signed({16'b0, prod_hi}) : $signed({16'b0, prod_hi});
   assign p_sum  = $signed({{32{base_ff[ax_ff][31]}}, base_ff[ax_ff]}) + p_term;

   for (genvar a = 0; a < 3; a++) begin : g_diff
      assign d_diff[a] = $signed({pos_rdata[32*a+31], pos_rdata[32*a +: 32]})
                       - $signed({pi_ff[a][31], pi_ff[a]});
   end

   // integer square root, two source bits per step
   assign sq_tmp   = {sqrem_ff, sqsrc_ff[63:62]};
   assign sq_trial = {2'b0, root_ff, 2'b01};
   assign sq_diff  = sq_tmp - sq_trial;

   assign d1_tmp  = {rem1_ff, num1_ff[46]};
   assign d1_div  = {1'b0, r2_ff};
   assign d1_ge   = d1_tmp >= d1_div;
   assign d1_diff = d1_tmp - d1_div;

   assign d2_tmp  = {rem2_ff, num2_ff[62]};
   assign d2_div  = {1'b0, root_ff};
   assign d2_ge   = d2_tmp >= d2_div;
   assign d2_diff = d2_tmp - d2_div;

   assign r2_cap = (racc_ff > nbls_pkg::R_CAP_WIDE) ? nbls_pkg::R_CAP : racc_ff[47:0];

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      n_in     = n_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      clr_in   = clr_ff;
      idx_in   = idx_ff;
      oob_in   = oob_ff;
      ax_in    = ax_ff;
      base_in  = base_ff;
      opa_in   = opa_ff;
      mulb_in  = mulb_ff;
      pi_in    = pi_ff;
      dmag_in  = dmag_ff;
      dneg_in  = dneg_ff;
      mass_in  = mass_ff;
      racc_in  = racc_ff;
      r2_in    = r2_ff;
      cnt_in   = cnt_ff;
      num1_in  = num1_ff;
      rem1_in  = rem1_ff;
      sqsrc_in = sqsrc_ff;
      sqrem_in = sqrem_ff;
      root_in  = root_ff;
      num2_in  = num2_ff;
      rem2_in  = rem2_ff;
      f_in     = f_ff;
      sum_in   = sum_ff;

      case (state_ff)
         nbls_pkg::ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CW'(MAX_BODIES - 1))
               state_in = nbls_pkg::ST_IDLE;
         end
         nbls_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  nbls_pkg::ACT_STEP: begin
                     n_in     = (32'(act_ff) > MAX_BODIES) ? CW'(MAX_BODIES) : CW'(act_ff);
                     i_in     = '0;
                     phase_in = nbls_pkg::PH_KICK1;
                     state_in = nbls_pkg::ST_P_RD;
                  end
                  nbls_pkg::ACT_READ: begin
                     idx_in   = req_index;
                     oob_in   = !req_in_range;
                     state_in = nbls_pkg::ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         nbls_pkg::ST_READ, nbls_pkg::ST_DONE: begin
            if (slot_free)
               state_in = nbls_pkg::ST_IDLE;
         end
         nbls_pkg::ST_P_RD: begin
            if (i_ff >= n_ff) begin
               i_in = '0;
               case (phase_ff)
                  nbls_pkg::PH_KICK1: phase_in = nbls_pkg::PH_DRIFT;
                  nbls_pkg::PH_DRIFT: begin
                     phase_in = nbls_pkg::PH_GRAV;
                     state_in = nbls_pkg::ST_G_RDI;
                  end
                  default: state_in = nbls_pkg::ST_DONE;
               endcase
            end else begin
               state_in = nbls_pkg::ST_P_LD;
            end
         end
         nbls_pkg::ST_P_LD: begin
            for (int a = 0; a < 3; a++) begin
               if (phase_ff == nbls_pkg::PH_DRIFT) begin
                  base_in[a] = $signed(pos_rdata[32*a +: 32]);
                  opa_in[a]  = $signed(vel_rdata[32*a +: 32]);
               end else begin
                  base_in[a] = $signed(vel_rdata[32*a +: 32]);
                  opa_in[a]  = $signed(acc_rdata[32*a +: 32]);
               end
            end
            mulb_in  = (phase_ff == nbls_pkg::PH_DRIFT) ? dt_ff : {1'b0, dt_ff[30:1]};
            ax_in    = '0;
            state_in = nbls_pkg::ST_P_MUL;
         end
         nbls_pkg::ST_P_MUL: state_in = nbls_pkg::ST_P_ADD;
         nbls_pkg::ST_P_ADD: begin
            base_in[ax_ff] = nbls_pkg::sat32(p_sum);
            if (ax_ff == 2'd2) begin
               state_in = nbls_pkg::ST_P_WR;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = nbls_pkg::ST_P_MUL;
            end
         end
         nbls_pkg::ST_P_WR: begin
            i_in     = i_ff + 1'b1;
            state_in = nbls_pkg::ST_P_RD;
         end
         nbls_pkg::ST_G_RDI: begin
            if (i_ff >= n_ff) begin
               i_in     = '0;
               phase_in = nbls_pkg::PH_KICK2;
               state_in = nbls_pkg::ST_P_RD;
            end else begin
               state_in = nbls_pkg::ST_G_LDI;
            end
         end
         nbls_pkg::ST_G_LDI: begin
            for (int a = 0; a < 3; a++) begin
               pi_in[a]  = $signed(pos_rdata[32*a +: 32]);
               sum_in[a] = '0;
            end
            j_in     = '0;
            state_in = nbls_pkg::ST_G_RDJ;
         end
         nbls_pkg::ST_G_RDJ: begin
            // acceleration write-back happens here when j runs out
            if (j_ff >= n_ff) begin
               i_in     = i_ff + 1'b1;
               state_in = nbls_pkg::ST_G_RDI;
            end else if (j_ff == i_ff) begin
               j_in = j_ff + 1'b1;
            end else begin
               state_in = nbls_pkg::ST_G_LDJ;
            end
         end
         nbls_pkg::ST_G_LDJ: begin
            for (int a = 0; a < 3; a++) begin
               dneg_in[a] = d_diff[a][32];
               dmag_in[a] = d_diff[a][32] ? 32'(-d_diff[a]) : d_diff[a][31:0];
            end
            mass_in  = mass_rdata;
            racc_in  = {19'b0, soft_ff};
            ax_in    = '0;
            state_in = nbls_pkg::ST_G_SQM;
         end
         nbls_pkg::ST_G_SQM: state_in = nbls_pkg::ST_G_SQA;
         nbls_pkg::ST_G_SQA: begin
            racc_in = racc_ff + {2'b0, prod_hi};
            if (ax_ff == 2'd2) begin
               state_in = nbls_pkg::ST_G_CAP;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = nbls_pkg::ST_G_SQM;
            end
         end
         nbls_pkg::ST_G_CAP: begin
            if (racc_ff == '0) begin
               // coincident bodies with no softening contribute nothing
               j_in     = j_ff + 1'b1;
               state_in = nbls_pkg::ST_G_RDJ;
            end else begin
               r2_in    = r2_cap;
               num1_in  = {mass_ff, 16'b0};
               rem1_in  = '0;
               sqsrc_in = {r2_cap, 16'b0};
               sqrem_in = '0;
               root_in  = '0;
               cnt_in   = '0;
               state_in = nbls_pkg::ST_G_DIV1;
            end
         end
         nbls_pkg::ST_G_DIV1: begin
            if (cnt_ff == nbls_pkg::DIV1_STEPS) begin
               num2_in  = {num1_ff, 16'b0};
               rem2_in  = '0;
               cnt_in   = '0;
               state_in = nbls_pkg::ST_G_DIV2;
            end else begin
               rem1_in = d1_ge ? d1_diff[47:0] : d1_tmp[47:0];
               num1_in = {num1_ff[45:0], d1_ge};
               if (cnt_ff < nbls_pkg::SQRT_STEPS) begin
                  sqsrc_in = {sqsrc_ff[61:0], 2'b00};
                  if (sq_tmp >= sq_trial) begin
                     sqrem_in = sq_diff[33:0];
                     root_in  = {root_ff[30:0], 1'b1};
                  end else begin
                     sqrem_in = sq_tmp[33:0];
                     root_in  = {root_ff[30:0], 1'b0};
                  end
               end
               cnt_in = cnt_ff + 6'd1;
            end
         end
         nbls_pkg::ST_G_DIV2: begin
            if (cnt_ff == nbls_pkg::DIV2_STEPS) begin
               f_in     = (num2_ff > nbls_pkg::F_CAP_WIDE) ? nbls_pkg::F_CAP : num2_ff[30:0];
               ax_in    = '0;
               state_in = nbls_pkg::ST_G_FM;
            end else begin
               rem2_in = d2_ge ? d2_diff[31:0] : d2_tmp[31:0];
               num2_in = {num2_ff[61:0], d2_ge};
               cnt_in  = cnt_ff + 6'd1;
            end
         end
         nbls_pkg::ST_G_FM: state_in = nbls_pkg::ST_G_FA;
         nbls_pkg::ST_G_FA: begin
            if (dneg_ff[ax_ff])
               sum_in[ax_ff] = sum_ff[ax_ff] - $signed({16'b0, prod_hi});
            else
               sum_in[ax_ff] = sum_ff[ax_ff] + $signed({16'b0, prod_hi});
            if (ax_ff == 2'd2) begin
               j_in     = j_ff + 1'b1;
               state_in = nbls_pkg::ST_G_RDJ;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = nbls_pkg::ST_G_FM;
            end
         end
         default: state_in = nbls_pkg::ST_IDLE;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      if (slot_free && state_ff == nbls_pkg::ST_READ) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = nbls_pkg::KIND_BODY;
         rsp_data_in  = oob_ff ? {199'b0, idx_ff}
                               : {7'b0, vel_rdata, pos_rdata, idx_ff};
      end else if (slot_free && state_ff == nbls_pkg::ST_DONE) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = nbls_pkg::KIND_DONE;
         rsp_data_in  = '0;
      end
   end

   // RAM port control
   always_comb begin
      pos_we    = 1'b0;
      vel_we    = 1'b0;
      acc_we    = 1'b0;
      mass_we   = 1'b0;
      pos_waddr = i_ff[AW-1:0];
      vel_waddr = i_ff[AW-1:0];
      acc_waddr = i_ff[AW-1:0];
      mass_waddr = AW'(req_index);
      pos_wdata = {base_ff[2], base_ff[1], base_ff[0]};
      vel_wdata = {base_ff[2], base_ff[1], base_ff[0]};
      acc_wdata = {nbls_pkg::sat32(sum_ff[2]), nbls_pkg::sat32(sum_ff[1]),
                   nbls_pkg::sat32(sum_ff[0])};
      pos_raddr = i_ff[AW-1:0];
      vel_raddr = i_ff[AW-1:0];
      acc_raddr = i_ff[AW-1:0];
      mass_raddr = j_ff[AW-1:0];

      case (state_ff)
         nbls_pkg::ST_CLEAR: begin
            acc_we    = 1'b1;
            acc_waddr = clr_ff[AW-1:0];
            acc_wdata = '0;
         end
         nbls_pkg::ST_IDLE: begin
            pos_raddr = AW'(req_index);
            vel_raddr = AW'(req_index);
            if (req_fire && req_tuser == nbls_pkg::ACT_LOAD && req_in_range) begin
               pos_we    = 1'b1;
               vel_we    = 1'b1;
               acc_we    = 1'b1;
               mass_we   = 1'b1;
               pos_waddr = AW'(req_index);
               vel_waddr = AW'(req_index);
               acc_waddr = AW'(req_index);
               pos_wdata = req_pos;
               vel_wdata = req_vel;
               acc_wdata = '0;
            end
         end
         nbls_pkg::ST_READ: begin
            pos_raddr = AW'(idx_ff);
            vel_raddr = AW'(idx_ff);
         end
         nbls_pkg::ST_P_WR: begin
            if (phase_ff == nbls_pkg::PH_DRIFT)
               pos_we = 1'b1;
            else
               vel_we = 1'b1;
         end
         nbls_pkg::ST_G_RDJ: begin
            pos_raddr = j_ff[AW-1:0];
            if (j_ff >= n_ff)
               acc_we = 1'b1;
         end
         default: ;
      endcase
   end

   nbls_ram #(.WIDTH(96), .DEPTH(MAX_BODIES)) u_pos_ram (
      .clock (clock),
      .we    (pos_we),
      .waddr (pos_waddr),
      .wdata (pos_wdata),
      .raddr (pos_raddr),
      .rdata (pos_rdata)
   );

   nbls_ram #(.WIDTH(96), .DEPTH(MAX_BODIES)) u_vel_ram (
      .clock (clock),
      .we    (vel_we),
      .waddr (vel_waddr),
      .wdata (vel_wdata),
      .raddr (vel_raddr),
      .rdata (vel_rdata)
   );

   nbls_ram #(.WIDTH(96), .DEPTH(MAX_BODIES)) u_acc_ram (
      .clock (clock),
      .we    (acc_we),
      .waddr (acc_waddr),
      .wdata (acc_wdata),
      .raddr (acc_raddr),
      .rdata (acc_rdata)
   );

   nbls_ram #(.WIDTH(31), .DEPTH(MAX_BODIES)) u_mass_ram (
      .clock (clock),
      .we    (mass_we),
      .waddr (mass_waddr),
      .wdata (req_mass),
      .raddr (mass_raddr),
      .rdata (mass_rdata)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nbls_pkg::ST_CLEAR;
         phase_ff     <= nbls_pkg::PH_KICK1;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         soft_ff      <= nbls_pkg::SOFTENING_RESET;
         dt_ff        <= nbls_pkg::TIME_STEP_RESET;
         act_ff       <= nbls_pkg::ACTIVE_RESET;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               nbls_pkg::CSR_SOFTENING: soft_ff <= csr_wdata;
               nbls_pkg::CSR_TIME_STEP: dt_ff   <= csr_wdata;
               nbls_pkg::CSR_ACTIVE:    act_ff  <= csr_wdata[9:0];
               default: ;
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      idx_ff      <= idx_in;
      oob_ff      <= oob_in;
      ax_ff       <= ax_in;
      base_ff     <= base_in;
      opa_ff      <= opa_in;
      mulb_ff     <= mulb_in;
      prod_ff     <= mul_a * mul_b;
      pi_ff       <= pi_in;
      dmag_ff     <= dmag_in;
      dneg_ff     <= dneg_in;
      mass_ff     <= mass_in;
      racc_ff     <= racc_in;
      r2_ff       <= r2_in;
      cnt_ff      <= cnt_in;
      num1_ff     <= num1_in;
      rem1_ff     <= rem1_in;
      sqsrc_ff    <= sqsrc_in;
      sqrem_ff    <= sqrem_in;
      root_ff     <= root_in;
      num2_ff     <= num2_in;
      rem2_ff     <= rem2_in;
      f_ff        <= f_in;
      sum_ff      <= sum_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
